// ----- design/psr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the polyline step resampler.
package psr_pkg;

   // Operand and result widths of the shared arithmetic unit.
   localparam int ARG_W = 32;
   localparam int OPB_W = 16;
   localparam int REM_W = 19;

   // Square root of a 32-bit value: one result bit per step.
   localparam int SQRT_STEPS = ARG_W / 2;

   // Step quotients never exceed the step length, so 13 quotient bits suffice
   // and the dividend (step length times a 16-bit magnitude) fits in 28 bits.
   localparam int QUO_BITS = 13;
   localparam int DVD_BITS = 28;
   localparam int CNT_W    = 5;

   typedef logic [1:0] arith_op_type;

   localparam arith_op_type OP_MUL  = 2'd0;
   localparam arith_op_type OP_SQRT = 2'd1;
   localparam arith_op_type OP_DIV  = 2'd2;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_cmd_type;

   typedef struct packed {
      logic             done;
      logic [ARG_W-1:0] result;
   } arith_sts_type;

endpackage

// ----- design/polyline_step_resampler.sv -----
`timescale 1ns / 1ps
// Top level of the polyline step resampler: sequencer, anchor state and output register.
//
// The block re-spaces a drawn stroke so that emitted points lie one step length
// apart. The first point of a stroke (tuser set, or any point before a stroke
// has begun) is echoed as a single beat with tlast set. For each later point the
// block walks from the last emitted point towards the new one, emitting a point
// every step length while the remaining distance is larger than the step, up to
// MAX_RUN points per input; tlast marks the final beat of each run, and an input
// that lies within one step of the anchor produces no beat at all. One input is
// worked on at a time and req_tready is low meanwhile. Any other input starts with a
// distance check, and each emitted point then takes the step computation, a
// further distance check and a load of the output register, which waits until
// the register is free. All of this runs on the single shared arithmetic unit,
// whose square root and two divisions are iterative. A finished beat waits in
// the output register, and the block carries on with the next input while it
// does. The step length is written through csr_wr_en and csr_wr_data; the
// user must do so only while the block is idle, as the block itself does not
// enforce it. It is clamped to 768..4096 when used.
module polyline_step_resampler #(
   parameter int MAX_RUN   = 60,
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Input points.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] point_x, [31:16] point_y
   input  logic        req_tuser,   // stroke_start
   // Resampled points.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] out_x, [31:16] out_y
   output logic        rsp_tlast,   // last_of_run
   // Step length register.
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data
);
   import psr_pkg::*;

   localparam int RUN_W    = $clog2(MAX_RUN + 1);
   localparam int STEP_MIN = 768;
   localparam int STEP_MAX = 4096;
   localparam int STEP_DEF = ((5 << FRAC_BITS) > STEP_MAX) ? STEP_MAX : (5 << FRAC_BITS);

   // Sequencer states. Each issue state starts the shared unit; the following
   // wait state holds until the unit reports completion.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MULX   = 4'd1;
   localparam logic [3:0] S_WMULX  = 4'd2;
   localparam logic [3:0] S_MULY   = 4'd3;
   localparam logic [3:0] S_WMULY  = 4'd4;
   localparam logic [3:0] S_SQRT   = 4'd5;
   localparam logic [3:0] S_WSQRT  = 4'd6;
   localparam logic [3:0] S_PUSH   = 4'd7;
   localparam logic [3:0] S_MULLX  = 4'd8;
   localparam logic [3:0] S_WMULLX = 4'd9;
   localparam logic [3:0] S_DIVX   = 4'd10;
   localparam logic [3:0] S_WDIVX  = 4'd11;
   localparam logic [3:0] S_MULLY  = 4'd12;
   localparam logic [3:0] S_WMULLY = 4'd13;
   localparam logic [3:0] S_DIVY   = 4'd14;
   localparam logic [3:0] S_WDIVY  = 4'd15;

   // Clamp a 17-bit signed value to the coordinate range.
   function automatic logic signed [15:0] sat_coord(input logic signed [16:0] v);
      logic signed [15:0] r;
      if (v < -17'sd16384) begin
         r = -16'sd16384;
      end else if (v > 17'sd16384) begin
         r = 16'sd16384;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   logic [3:0]         state_ff, state_in;
   logic [12:0]        step_ff, step_in;
   logic signed [15:0] px_ff, px_in, py_ff, py_in;
   logic signed [15:0] ax_ff, ax_in, ay_ff, ay_in;
   logic               av_ff, av_in;
   logic [RUN_W-1:0]   count_ff, count_in;
   logic [ARG_W-1:0]   d2_ff, d2_in;
   logic [ARG_W-1:0]   work_ff, work_in;
   logic [OPB_W-1:0]   dist_ff, dist_in;
   logic [QUO_BITS-1:0] qx_ff, qx_in;
   logic               push_last_ff, push_last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   arith_cmd_type      cmd;
   arith_sts_type      sts;
   logic [ARG_W-1:0]   opa;
   logic [OPB_W-1:0]   opb;

   logic [12:0]        len;
   logic signed [16:0] dx, dy;
   logic [OPB_W-1:0]   adx, ady;
   logic               far;
   logic               slot_free;
   logic signed [16:0] step_x, step_y, sum_x, sum_y;

   psr_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .opa   (opa),
      .opb   (opb),
      .sts   (sts)
   );

   // Clamped step length, distance terms from the anchor to the input point, next anchor.
   always_comb begin
      len = step_ff;
      if (step_ff < 13'(STEP_MIN)) begin
         len = 13'(STEP_MIN);
      end else if (step_ff > 13'(STEP_MAX)) begin
         len = 13'(STEP_MAX);
      end
      dx  = $signed({px_ff[15], px_ff}) - $signed({ax_ff[15], ax_ff});
      dy  = $signed({py_ff[15], py_ff}) - $signed({ay_ff[15], ay_ff});
      adx = dx[16] ? 16'(-dx) : dx[15:0];
      ady = dy[16] ? 16'(-dy) : dy[15:0];
      far = (sts.result[OPB_W-1:0] > {3'b000, len}) && (count_ff < RUN_W'(MAX_RUN));
      // The quotient is a magnitude and takes the sign of the difference, which
      // truncates each step component towards zero.
      step_x = $signed({4'b0000, qx_ff});
      step_y = $signed({4'b0000, sts.result[QUO_BITS-1:0]});
      sum_x  = $signed({ax_ff[15], ax_ff}) + (dx[16] ? -step_x : step_x);
      sum_y  = $signed({ay_ff[15], ay_ff}) + (dy[16] ? -step_y : step_y);
   end

   // Commands to the shared unit.
   always_comb begin
      cmd.start = 1'b0;
      cmd.op    = OP_MUL;
      opa       = '0;
      opb       = '0;
      case (state_ff)
         S_MULX: begin
            cmd.start = 1'b1;
            opa       = {{(ARG_W-OPB_W){1'b0}}, adx};
            opb       = adx;
         end
         S_MULY: begin
            cmd.start = 1'b1;
            opa       = {{(ARG_W-OPB_W){1'b0}}, ady};
            opb       = ady;
         end
         S_SQRT: begin
            cmd.start = 1'b1;
            cmd.op    = OP_SQRT;
            opa       = d2_ff;
         end
         S_MULLX: begin
            cmd.start = 1'b1;
            opa       = {{(ARG_W-13){1'b0}}, len};
            opb       = adx;
         end
         S_MULLY: begin
            cmd.start = 1'b1;
            opa       = {{(ARG_W-13){1'b0}}, len};
            opb       = ady;
         end
         S_DIVX, S_DIVY: begin
            cmd.start = 1'b1;
            cmd.op    = OP_DIV;
            opa       = work_ff;
            opb       = dist_ff;
         end
         default: begin
            cmd.start = 1'b0;
         end
      endcase
   end

   // Sequencer. A computed point becomes the anchor at once but is only sent
   // after the next distance check, which decides whether it ends the run.
   always_comb begin
      state_in     = state_ff;
      step_in      = csr_wr_en ? csr_wr_data : step_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      av_in        = av_ff;
      count_in     = count_ff;
      d2_in        = d2_ff;
      work_in      = work_ff;
      dist_in      = dist_ff;
      qx_in        = qx_ff;
      push_last_in = push_last_ff;
      slot_free    = ~rsp_valid_ff | rsp_tready;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               px_in = sat_coord($signed({req_tdata[15], req_tdata[15:0]}));
               py_in = sat_coord($signed({req_tdata[31], req_tdata[31:16]}));
               if (req_tuser || !av_ff) begin
                  ax_in        = px_in;
                  ay_in        = py_in;
                  av_in        = 1'b1;
                  push_last_in = 1'b1;
                  state_in     = S_PUSH;
               end else begin
                  count_in = '0;
                  state_in = S_MULX;
               end
            end
         end
         S_MULX:   state_in = S_WMULX;
         S_WMULX: begin
            if (sts.done) begin
               d2_in    = sts.result;
               state_in = S_MULY;
            end
         end
         S_MULY:   state_in = S_WMULY;
         S_WMULY: begin
            if (sts.done) begin
               d2_in    = d2_ff + sts.result;
               state_in = S_SQRT;
            end
         end
         S_SQRT:   state_in = S_WSQRT;
         S_WSQRT: begin
            if (sts.done) begin
               dist_in = sts.result[OPB_W-1:0];
               if (count_ff != '0) begin
                  push_last_in = ~far;
                  state_in     = S_PUSH;
               end else if (far) begin
                  state_in = S_MULLX;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PUSH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {ay_ff, ax_ff};
               rsp_last_in  = push_last_ff;
               state_in     = push_last_ff ? S_IDLE : S_MULLX;
            end
         end
         S_MULLX:  state_in = S_WMULLX;
         S_WMULLX: begin
            if (sts.done) begin
               work_in  = sts.result;
               state_in = S_DIVX;
            end
         end
         S_DIVX:   state_in = S_WDIVX;
         S_WDIVX: begin
            if (sts.done) begin
               qx_in    = sts.result[QUO_BITS-1:0];
               state_in = S_MULLY;
            end
         end
         S_MULLY:  state_in = S_WMULLY;
         S_WMULLY: begin
            if (sts.done) begin
               work_in  = sts.result;
               state_in = S_DIVY;
            end
         end
         S_DIVY:   state_in = S_WDIVY;
         S_WDIVY: begin
            if (sts.done) begin
               ax_in    = sat_coord(sum_x);
               ay_in    = sat_coord(sum_y);
               count_in = count_ff + RUN_W'(1);
               state_in = S_MULX;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= 13'(STEP_DEF);
         ax_ff        <= '0;
         ay_ff        <= '0;
         av_ff        <= 1'b0;
         count_ff     <= '0;
         push_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ax_ff        <= ax_in;
         ay_ff        <= ay_in;
         av_ff        <= av_in;
         count_ff     <= count_in;
         push_last_ff <= push_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff       <= px_in;
      py_ff       <= py_in;
      d2_ff       <= d2_in;
      work_ff     <= work_in;
      dist_ff     <= dist_in;
      qx_ff       <= qx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- design/psr_arith.sv -----
`timescale 1ns / 1ps
// Shared arithmetic unit: registered multiply, iterative square root and divide.
module psr_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  psr_pkg::arith_cmd_type cmd,
   input  logic [psr_pkg::ARG_W-1:0] opa,
   input  logic [psr_pkg::OPB_W-1:0] opb,
   output psr_pkg::arith_sts_type sts
);
   import psr_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   arith_op_type       op_ff, op_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [OPB_W-1:0]   q_ff, q_in;
   logic [ARG_W-1:0]   src_ff, src_in;
   logic [OPB_W-1:0]   dvs_ff, dvs_in;
   logic [ARG_W-1:0]   prod_ff, prod_in;

   logic               is_sqrt;
   logic [REM_W-1:0]   sub_a, sub_b, rem_step;
   logic [REM_W:0]     diff;
   logic               ge;

   // The one compare-and-subtract shared by both iterative operations.
   always_comb begin
      is_sqrt  = (op_ff == OP_SQRT);
      sub_a    = is_sqrt ? {rem_ff[REM_W-3:0], src_ff[ARG_W-1 -: 2]}
                         : {2'b00, rem_ff[OPB_W-1:0], src_ff[ARG_W-1]};
      sub_b    = is_sqrt ? {1'b0, q_ff, 2'b01}
                         : {3'b000, dvs_ff};
      diff     = {1'b0, sub_a} - {1'b0, sub_b};
      ge       = ~diff[REM_W];
      rem_step = ge ? diff[REM_W-1:0] : sub_a;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      src_in  = src_ff;
      dvs_in  = dvs_ff;
      prod_in = prod_ff;
      if (cmd.start) begin
         op_in = cmd.op;
         case (cmd.op)
            OP_MUL: begin
               prod_in = opa[OPB_W-1:0] * opb;
               done_in = 1'b1;
            end
            OP_SQRT: begin
               rem_in  = '0;
               q_in    = '0;
               src_in  = opa;
               cnt_in  = CNT_W'(SQRT_STEPS);
               busy_in = 1'b1;
            end
            OP_DIV: begin
               rem_in  = REM_W'(opa[DVD_BITS-1:QUO_BITS]);
               q_in    = '0;
               src_in  = {opa[QUO_BITS-1:0], {(ARG_W-QUO_BITS){1'b0}}};
               dvs_in  = opb;
               cnt_in  = CNT_W'(QUO_BITS);
               busy_in = 1'b1;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end else if (busy_ff) begin
         rem_in = rem_step;
         q_in   = {q_ff[OPB_W-2:0], ge};
         src_in = is_sqrt ? {src_ff[ARG_W-3:0], 2'b00} : {src_ff[ARG_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= OP_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      src_ff  <= src_in;
      dvs_ff  <= dvs_in;
      prod_ff <= prod_in;
   end

   assign sts.done   = done_ff;
   assign sts.result = (op_ff == OP_MUL) ? prod_ff : {{(ARG_W-OPB_W){1'b0}}, q_ff};

endmodule

// ----- design/psr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the polyline step resampler, bound to the top level.
module psr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // Accepting a point always starts work, so the block is busy next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input still ready after a point was accepted");

   // New results only appear while a point is being worked on.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while the block was idle");

   // Emitted coordinates stay inside the saturated range.
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) >= -16'sd16384)
                  && ($signed(rsp_tdata[15:0]) <= 16'sd16384)
                  && ($signed(rsp_tdata[31:16]) >= -16'sd16384)
                  && ($signed(rsp_tdata[31:16]) <= 16'sd16384))
      else $error("result coordinate out of range");

endmodule

bind polyline_step_resampler psr_checker u_psr_checker (.*);

// ----- dv/polyline_step_resampler_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the polyline step resampler.
//
// Directed tests come first, then a long randomised stroke test. Each point is
// driven on the req_ stream by one shared task. The moment the DUT accepts a
// point, an in-bench model of the resampler works out every beat that the point
// should cause and queues them. A separate process takes beats from the rsp_
// stream and checks them field by field against the oldest queued beat. Both
// streams idle at random, and some stretches have no idling at all. The step
// length register is only written once the queue has emptied and the block has
// had time to finish any point that produced no beats.
module polyline_step_resampler_test;

   // Clamp limits and default of the step length, as the block applies them.
   localparam int STEP_RESET   = 1280;
   localparam int STEP_FLOOR   = 768;
   localparam int STEP_CEILING = 4096;
   // Coordinates saturate to plus or minus this value.
   localparam int COORD_LIMIT  = 16384;
   localparam int MAX_RUN      = 60;

   // The longest idle draw on either stream, in cycles.
   localparam int MAX_IDLE      = 12;
   // After the last expected beat, a point that causes no beat may still be in
   // its final distance check, so allow a generous margin.
   localparam int SETTLE_CYCLES = 100;
   localparam int DRAIN_LIMIT   = 100000;
   // A full 60-point run costs the most time, and more once every beat
   // also sits out the longest receiver stall. Taking that for every point of
   // the run and multiplying it gives a limit that only a hung block reaches.
   localparam int CYCLE_LIMIT   = 6000000;

   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_POINTS  = 49;

   typedef struct packed {
      int x;
      int y;
      bit last;
   } point_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [15:0] point_x, [31:16] point_y
   logic        req_tuser = 1'b0; // stroke_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [15:0] out_x, [31:16] out_y
   logic        rsp_tlast;        // last_of_run
   logic        csr_wr_en = 1'b0;
   logic [12:0] csr_wr_data = '0;

   // Beats that the model has predicted but the DUT has not yet delivered.
   point_beat_type planned_points[$];

   // Model state: the anchor (last emitted point) and the step length register.
   int          pen_x;
   int          pen_y;
   bit          pen_down;
   logic [12:0] spacing;

   // Idle switches for the two streams, redrawn every 18 points of a random phase.
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;

   int error_count    = 0;
   int points_sent    = 0;
   int directed_count = 0;
   int beats_checked  = 0;
   int step_writes    = 0;
   int cycle_count    = 0;

   polyline_step_resampler DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   function automatic int clamp_coord(input int v);
      if (v < -COORD_LIMIT) return -COORD_LIMIT;
      if (v > COORD_LIMIT) return COORD_LIMIT;
      return v;
   endfunction

   // The step length that the block actually uses: the register, clamped.
   function automatic int eff_spacing();
      int len;
      len = spacing;
      if (len < STEP_FLOOR) len = STEP_FLOOR;
      if (len > STEP_CEILING) len = STEP_CEILING;
      return len;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      // Keep the log readable if the block is badly broken; every error is still counted.
      if (error_count <= 100)
         $display("ERROR at beat %0d: %s is %0d, expected %0d", beats_checked, what, got, want);
   endtask

   // Works out every beat that one accepted point causes, and moves the anchor.
   task automatic predict_resample(input logic [15:0] raw_x, input logic [15:0] raw_y,
                                   input bit start);
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      int px, py, len, dx, dy, reach, emitted, b;
      longint d2, root, trial;
      point_beat_type beat;
      point_beat_type run[$];
      sx = raw_x;
      sy = raw_y;
      px = clamp_coord(sx);
      py = clamp_coord(sy);
      len = eff_spacing();
      // A new stroke, or any point before the first stroke, is echoed as one beat.
      if (start || !pen_down) begin
         pen_x = px;
         pen_y = py;
         pen_down = 1'b1;
         beat = '{x: px, y: py, last: 1'b1};
         planned_points.insert(planned_points.size(), beat);
         return;
      end
      emitted = 0;
      while (emitted < MAX_RUN) begin
         dx = px - pen_x;
         dy = py - pen_y;
         d2 = longint'(dx) * dx + longint'(dy) * dy;
         // Floor of the square root, found one result bit at a time.
         root = 0;
         for (b = 16; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= d2) root = trial;
         end
         reach = int'(root);
         // Within one step of the anchor: the walk stops here.
         if (reach <= len) break;
         // Integer division truncates towards zero, as the block does.
         pen_x = clamp_coord(pen_x + (len * dx) / reach);
         pen_y = clamp_coord(pen_y + (len * dy) / reach);
         beat = '{x: pen_x, y: pen_y, last: 1'b0};
         run.insert(run.size(), beat);
         emitted++;
      end
      if (emitted > 0) run[emitted - 1].last = 1'b1;
      foreach (run[i]) planned_points.insert(planned_points.size(), run[i]);
   endtask

   // Drives one point after a random gap and waits for the DUT to take the beat.
   // tvalid stays high afterwards, so that back-to-back points need no toggling.
   task automatic send_point(input int x, input int y, input bit start);
      int gap;
      logic [15:0] wx, wy;
      gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      // Values beyond 16 bits are pinned to the field extremes, not wrapped.
      if (x > 32767) x = 32767;
      if (x < -32768) x = -32768;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      wx = x[15:0];
      wy = y[15:0];
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {wy, wx};
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_resample(wx, wy, start);
      points_sent++;
   endtask

   // Lowers the input stream, waits for every queued beat and then lets the
   // block finish whatever point may still be in its final distance check.
   task automatic settle();
      int waited;
      waited = 0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (planned_points.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the step length register while the block is idle.
   task automatic write_spacing(input logic [12:0] value);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      spacing = value;
      step_writes++;
   endtask

   // Straight after reset no stroke has started, so a plain point is echoed.
   task automatic test_first_point_without_start();
      send_point(256, -512, 1'b0);
   endtask

   // The reset step length of 5.0 governs the walk before any register write.
   task automatic test_reset_step_walk();
      send_point(256 + 4500, -512, 1'b0);
      send_point(pen_x - 3000, pen_y - 3000, 1'b0);
   endtask

   // A point exactly one step away, one barely away and one on the anchor
   // itself must all produce no beat at all.
   task automatic test_close_points();
      send_point(pen_x + eff_spacing(), pen_y, 1'b0);
      send_point(pen_x + 1, pen_y - 1, 1'b0);
      send_point(pen_x, pen_y, 1'b0);
   endtask

   // A stroke start in mid-stroke is echoed however far away it lies.
   task automatic test_restart_mid_stroke();
      send_point(-9000, 7000, 1'b1);
   endtask

   // Coordinates beyond the field range saturate, both when echoed and when
   // used as the target of a walk.
   task automatic test_coordinate_saturation();
      send_point(32767, -32768, 1'b1);
      send_point(-32768, 32767, 1'b0);
      send_point(COORD_LIMIT + 1, -COORD_LIMIT - 1, 1'b1);
   endtask

   // Register values below and above the usable range are clamped when used.
   task automatic test_step_clamping();
      write_spacing(13'd0);
      send_point(pen_x - 2000, pen_y, 1'b0);
      write_spacing(13'(STEP_FLOOR - 1));
      send_point(pen_x, pen_y + 1600, 1'b0);
      write_spacing(13'(STEP_FLOOR));
      send_point(pen_x + 1700, pen_y + 900, 1'b0);
      write_spacing(13'h1FFF);
      send_point(pen_x + 9000, pen_y - 300, 1'b0);
      write_spacing(13'(STEP_CEILING + 1));
      write_spacing(13'(STEP_CEILING));
      send_point(pen_x - 9000, pen_y - 4000, 1'b0);
   endtask

   // With the shortest step a corner-to-corner jump reaches the cap on
   // points per input; a second jump runs almost along one axis.
   task automatic test_long_jump();
      write_spacing(13'(STEP_FLOOR));
      send_point(-COORD_LIMIT, -COORD_LIMIT, 1'b1);
      send_point(COORD_LIMIT, COORD_LIMIT, 1'b0);
      send_point(COORD_LIMIT, -COORD_LIMIT, 1'b0);
   endtask

   // Random strokes in several phases, each with its own step length. Most
   // points move a short way from the anchor so that runs of one to a few
   // beats dominate; the rest restart the stroke, jump far, or are raw noise.
   task automatic test_random_strokes();
      int phase, n, kind, len, x, y;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: write_spacing(13'($urandom_range(STEP_FLOOR, STEP_CEILING)));
            1: write_spacing(13'h1FFF);
            2: write_spacing(13'd0);
            3: write_spacing(13'($urandom_range(0, 8191)));
            default: write_spacing(13'(STEP_RESET));
         endcase
         send_point($urandom_range(0, 2 * COORD_LIMIT) - COORD_LIMIT,
                    $urandom_range(0, 2 * COORD_LIMIT) - COORD_LIMIT, 1'b1);
         for (n = 0; n < PHASE_POINTS; n++) begin
            if (n % 18 == 0) begin
               tx_idle_on = ($urandom_range(0, 3) != 0);
               rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            len = eff_spacing();
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
               send_point($urandom_range(0, 2 * COORD_LIMIT) - COORD_LIMIT,
                          $urandom_range(0, 2 * COORD_LIMIT) - COORD_LIMIT, 1'b1);
            end else if (kind < 16) begin
               // Raw 16-bit noise reaches every bit of both coordinates.
               x = $urandom_range(0, 65535);
               y = $urandom_range(0, 65535);
               send_point(x - 32768, y - 32768, 1'($urandom_range(0, 1)));
            end else if (kind < 20) begin
               send_point($urandom_range(0, 4 * COORD_LIMIT) - 2 * COORD_LIMIT,
                          $urandom_range(0, 4 * COORD_LIMIT) - 2 * COORD_LIMIT, 1'b0);
            end else begin
               x = pen_x + int'($urandom_range(0, 6 * len)) - 3 * len;
               y = pen_y + int'($urandom_range(0, 6 * len)) - 3 * len;
               send_point(x, y, 1'b0);
            end
         end
      end
   endtask

   // Result side: stall at random before each beat, then check what arrives.
   initial begin : beat_checker
      int stall;
      logic signed [15:0] got_x;
      logic signed [15:0] got_y;
      point_beat_type want;
      wait (reset == 1'b0);
      forever begin
         stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got_x = rsp_tdata[15:0];
         got_y = rsp_tdata[31:16];
         if (planned_points.size() == 0) begin
            report_mismatch("unexpected beat, out_x", got_x, 0);
         end else begin
            want = planned_points.pop_front();
            if (int'(got_x) != want.x) report_mismatch("out_x", got_x, want.x);
            if (int'(got_y) != want.y) report_mismatch("out_y", got_y, want.y);
            if (rsp_tlast !== want.last) report_mismatch("last_of_run", rsp_tlast, want.last);
         end
         beats_checked++;
      end
   end

   // Watchdog: a hung block ends the run here.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** polyline_step_resampler: FAILED **");
      $finish;
   end

   initial begin : sequencer
      pen_x = 0;
      pen_y = 0;
      pen_down = 1'b0;
      spacing = 13'(STEP_RESET);
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_first_point_without_start();
      test_reset_step_walk();
      test_close_points();
      test_restart_mid_stroke();
      test_coordinate_saturation();
      test_step_clamping();
      test_long_jump();
      directed_count = points_sent;
      test_random_strokes();

      settle();
      if (planned_points.size() != 0)
         report_mismatch("beats never delivered", 0, planned_points.size());

      $display("Sent %0d points (%0d directed) and checked %0d resampled beats.",
               points_sent, directed_count, beats_checked);
      $display("Step length was written %0d times, across clamped, extreme and default values.",
               step_writes);
      if (error_count == 0) begin
         $display("** polyline_step_resampler: PASSED **");
      end else begin
         $display("** polyline_step_resampler: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/psr_pkg.sv
design/psr_arith.sv
design/polyline_step_resampler.sv
design/psr_checker.sv
dv/polyline_step_resampler_test.sv
